// File: design/uerd_pkg.sv
// Shared types, constants and code tables of the ultrasonic echo ranger display.
package uerd_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned ADDR_W          = 4;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned SCALE_W         = 16;
  localparam int unsigned DIST_W          = 12;

  localparam logic [7:0]  TRIG_TICKS_RST = 8'd18;
  localparam logic [15:0] MM_SCALE_RST   = 16'd12089;
  localparam logic [11:0] MIN_MM_RST     = 12'd20;
  localparam logic [11:0] MAX_MM_RST     = 12'd4000;

  localparam logic [7:0]  SEG_BLANK      = 8'hFF;
  localparam logic [7:0]  SEG_POINT_MASK = 8'h7F;
  localparam int unsigned BAR_STEP       = 500;
  localparam int unsigned BAR_LEVELS     = 7;

  typedef enum logic [1:0] {
    REG_TRIG_TICKS = 2'd0,
    REG_MM_SCALE   = 2'd1,
    REG_MIN_MM     = 2'd2,
    REG_MAX_MM     = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_TRIG  = 4'b0010,
    PH_WAIT  = 4'b0100,
    PH_COUNT = 4'b1000
  } phase_e;

  // load strobes of the two display stages
  typedef struct packed {
    logic ld_div;
    logic ld_out;
  } stage_ld_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] bar_code(input logic [2:0] idx);
    logic [7:0] code;
    unique case (idx)
      3'd0:    code = 8'h7F;
      3'd1:    code = 8'h3F;
      3'd2:    code = 8'h1F;
      3'd3:    code = 8'h0F;
      3'd4:    code = 8'h07;
      3'd5:    code = 8'h03;
      3'd6:    code = 8'h01;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// File: design/uerd_display.sv
// Two-stage decimal split and seven-segment / bar decode of the held distance.
module uerd_display (
  input  logic                         clk_i,
  input  uerd_pkg::stage_ld_t          ld_i,
  input  logic [uerd_pkg::DIST_W-1:0]  dist_i,
  output logic [uerd_pkg::DIST_W-1:0]  distance_o,
  output logic [7:0]                   seg_units_o,
  output logic [7:0]                   seg_tens_o,
  output logic [7:0]                   seg_hundreds_o,
  output logic [7:0]                   seg_thousands_o,
  output logic [7:0]                   bar_leds_o
);
  import uerd_pkg::*;

  // reciprocal constants, exact for every 12-bit distance
  localparam logic [15:0] Recip10   = 16'd52429;
  localparam logic [12:0] Recip100  = 13'd5243;
  localparam logic [12:0] Recip1000 = 13'd4195;

  logic [27:0] p10;
  logic [24:0] p100;
  logic [24:0] p1000;

  logic [DIST_W-1:0] dist_q;
  logic [8:0]        q10_q;
  logic [5:0]        q100_q;
  logic [2:0]        q1000_q;

  assign p10   = 28'(dist_i) * 28'(Recip10);
  assign p100  = 25'(dist_i) * 25'(Recip100);
  assign p1000 = 25'(dist_i) * 25'(Recip1000);

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_div) begin
      dist_q  <= dist_i;
      q10_q   <= p10[27:19];
      q100_q  <= p100[24:19];
      q1000_q <= p1000[24:22];
    end
  end

  logic [DIST_W-1:0] units_w;
  logic [8:0]        tens_w;
  logic [5:0]        hund_w;
  logic [3:0]        d_u, d_t, d_h, d_k;
  logic [DIST_W-1:0] dm1;
  logic [2:0]        bar_idx;
  logic [7:0]        su_d, st_d, sh_d, sk_d, bar_d;

  always_comb begin
    units_w = dist_q - 12'(q10_q) * 12'd10;
    tens_w  = q10_q - 9'(q100_q) * 9'd10;
    hund_w  = q100_q - 6'(q1000_q) * 6'd10;
    d_u = units_w[3:0];
    d_t = tens_w[3:0];
    d_h = hund_w[3:0];
    d_k = 4'(q1000_q);

    sk_d = (d_k != 4'd0) ? seg_code(d_k) : SEG_BLANK;
    sh_d = (d_k != 4'd0 || d_h != 4'd0) ? seg_code(d_h) : SEG_BLANK;
    st_d = ((d_k != 4'd0 || d_h != 4'd0 || d_t != 4'd0) ? seg_code(d_t) : SEG_BLANK)
           & SEG_POINT_MASK;
    su_d = seg_code(d_u);

    // zero wraps to the top, so the level saturates
    dm1     = dist_q - 12'd1;
    bar_idx = '0;
    for (int i = 1; i <= BAR_LEVELS; i++) begin
      bar_idx = bar_idx + 3'(dm1 >= 12'(i * BAR_STEP));
    end
    bar_d = bar_code(bar_idx);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_out) begin
      distance_o      <= dist_q;
      seg_units_o     <= su_d;
      seg_tens_o      <= st_d;
      seg_hundreds_o  <= sh_d;
      seg_thousands_o <= sk_d;
      bar_leds_o      <= bar_d;
    end
  end

endmodule

// File: design/ultrasonic_echo_ranger_display_core.sv
// Top level of the ultrasonic echo ranger with seven-segment and bar read-out.
// Register stages from an input beat to its result beat: sequencer, multiply,
// clamp, decimal split, segment decode; the COUNT_WIDTHx16 scale multiply is alone.
// Throughput: one beat per cycle unless out_ready_i stalls the output stage.
// Reset: rst_ni clears the sequencer, counters, held distance and pipeline valids,
// and loads the register defaults; no clearing pass is needed.
module ultrasonic_echo_ranger_display_core #(
  parameter int unsigned COUNT_WIDTH = uerd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [uerd_pkg::ADDR_W-1:0]  paddr,
  input  logic [uerd_pkg::DATA_W-1:0]  pwdata,
  output logic [uerd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         start_req_i,
  input  logic                         echo_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         trig_o,
  output logic                         done_res_o,
  output logic [uerd_pkg::DIST_W-1:0]  distance_mm_o,
  output logic                         overflowed_o,
  output logic [7:0]                   seg_units_o,
  output logic [7:0]                   seg_tens_o,
  output logic [7:0]                   seg_hundreds_o,
  output logic [7:0]                   seg_thousands_o,
  output logic [7:0]                   bar_leds_o
);
  import uerd_pkg::*;

  localparam int unsigned PROD_W = COUNT_WIDTH + SCALE_W;
  localparam int unsigned CMP_W  = (COUNT_WIDTH > DIST_W) ? COUNT_WIDTH : DIST_W;
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  // configuration registers
  logic [7:0]        trig_ticks_q;
  logic [15:0]       mm_scale_q;
  logic [DIST_W-1:0] min_mm_q, max_mm_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q <= TRIG_TICKS_RST;
      mm_scale_q   <= MM_SCALE_RST;
      min_mm_q     <= MIN_MM_RST;
      max_mm_q     <= MAX_MM_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TRIG_TICKS: trig_ticks_q <= pwdata[7:0];
        REG_MM_SCALE:   mm_scale_q   <= pwdata[15:0];
        REG_MIN_MM:     min_mm_q     <= pwdata[DIST_W-1:0];
        REG_MAX_MM:     max_mm_q     <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TRIG_TICKS: prdata = DATA_W'(trig_ticks_q);
      REG_MM_SCALE:   prdata = DATA_W'(mm_scale_q);
      REG_MIN_MM:     prdata = DATA_W'(min_mm_q);
      REG_MAX_MM:     prdata = DATA_W'(max_mm_q);
      default:        prdata = '0;
    endcase
  end

  // pipeline flow control
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic in_acc;

  assign rdy5       = !v5_q || out_ready_i;
  assign rdy4       = !v4_q || rdy5;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign in_acc     = in_valid_i && rdy1;
  assign out_valid_o = v5_q;

  // measurement sequencer
  phase_e                 phase_q, phase_d;
  logic [7:0]             timer_q, timer_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_sel;
  logic                   ovf_q, ovf_d, done_d;

  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    done_d  = 1'b0;
    cnt_sel = ovf_q ? CntMax : cnt_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_req_i) begin
          phase_d = PH_TRIG;
          timer_d = (trig_ticks_q == 8'd0) ? 8'd0 : trig_ticks_q - 8'd1;
          cnt_d   = '0;
          ovf_d   = 1'b0;
        end
      end
      PH_TRIG: begin
        if (timer_q == 8'd0) begin
          phase_d = PH_WAIT;
        end else begin
          timer_d = timer_q - 8'd1;
        end
      end
      PH_WAIT: begin
        if (echo_i) begin
          phase_d = PH_COUNT;
          cnt_d   = COUNT_WIDTH'(1);
        end
      end
      PH_COUNT: begin
        if (echo_i) begin
          if (cnt_q == CntMax) begin
            cnt_d = '0;
            ovf_d = 1'b1;
          end else begin
            cnt_d = cnt_q + COUNT_WIDTH'(1);
          end
        end else begin
          done_d  = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  // stage flags and payload
  logic                   trig1_q, done1_q, ovf1_q;
  logic [COUNT_WIDTH-1:0] cnt1_q;
  logic                   trig2_q, done2_q, ovf2_q;
  logic [PROD_W-1:0]      prod2_q;
  logic                   trig3_q, done3_q, ovf3_q;
  logic [DIST_W-1:0]      dist3_q, clamp_d;
  logic                   trig4_q, done4_q, ovf4_q;
  logic                   trig5_q, done5_q, ovf5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      trig1_q <= (phase_d == PH_TRIG);
      done1_q <= done_d;
      ovf1_q  <= ovf_d;
      cnt1_q  <= cnt_sel;
    end
    if (rdy2) begin
      trig2_q <= trig1_q;
      done2_q <= done1_q;
      ovf2_q  <= ovf1_q;
      prod2_q <= PROD_W'(cnt1_q) * PROD_W'(mm_scale_q);
    end
    if (rdy3) begin
      trig3_q <= trig2_q;
      done3_q <= done2_q;
      ovf3_q  <= ovf2_q;
    end
    if (rdy4) begin
      trig4_q <= trig3_q;
      done4_q <= done3_q;
      ovf4_q  <= ovf3_q;
    end
    if (rdy5 && v4_q) begin
      trig5_q <= trig4_q;
      done5_q <= done4_q;
      ovf5_q  <= ovf4_q;
    end
  end

  // truncate the Q16 product and clamp, upper bound first
  logic [CMP_W-1:0] mm_ext;

  always_comb begin
    mm_ext = CMP_W'(prod2_q[PROD_W-1:SCALE_W]);
    if (mm_ext > CMP_W'(max_mm_q)) begin
      clamp_d = max_mm_q;
    end else if (mm_ext < CMP_W'(min_mm_q)) begin
      clamp_d = min_mm_q;
    end else begin
      clamp_d = mm_ext[DIST_W-1:0];
    end
  end

  // held distance: only a finishing beat replaces it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist3_q <= '0;
    end else if (rdy3 && v2_q && done2_q) begin
      dist3_q <= clamp_d;
    end
  end

  stage_ld_t disp_ld;
  assign disp_ld.ld_div = rdy4;
  assign disp_ld.ld_out = rdy5 && v4_q;

  uerd_display u_display (
    .clk_i           (clk_i),
    .ld_i            (disp_ld),
    .dist_i          (dist3_q),
    .distance_o      (distance_mm_o),
    .seg_units_o     (seg_units_o),
    .seg_tens_o      (seg_tens_o),
    .seg_hundreds_o  (seg_hundreds_o),
    .seg_thousands_o (seg_thousands_o),
    .bar_leds_o      (bar_leds_o)
  );

  assign trig_o       = trig5_q;
  assign done_res_o   = done5_q;
  assign overflowed_o = ovf5_q;

endmodule

// File: design/uerd_checker.sv
// Port-level assertions of the echo ranger core and their bind.
module uerd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         trig_o,
  input logic                         done_res_o,
  input logic [uerd_pkg::DIST_W-1:0]  distance_mm_o,
  input logic [7:0]                   seg_units_o,
  input logic [7:0]                   seg_tens_o,
  input logic [7:0]                   bar_leds_o
);

  // a finishing beat leaves the sequencer idle, so trig is low
  a_done_no_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !trig_o)
    else $error("trig high on a finishing beat");

  // zero distance shows a lone zero with the point and an empty bar
  a_zero_display: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && distance_mm_o == '0 |->
      seg_units_o == 8'hC0 && seg_tens_o == 8'h7F && bar_leds_o == 8'h00)
    else $error("bad read-out for zero distance");

  // an empty output side never holds off input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_mm_o))
    else $error("stalled result beat changed");

endmodule

bind ultrasonic_echo_ranger_display_core uerd_checker u_uerd_checker (.*);
